// ===== src/osts_pkg.sv =====
package osts_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [SLOT_W-1:0] LAST_IDX      = SLOT_W'(SLOTS - 1);
    localparam logic [7:0]        SLOT_ID_LIMIT = 8'(SLOTS);

    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_TICK       = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        K_REG,
        K_UNREG,
        K_TICK,
        K_NOP,
        K_RANGE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [31:0]        duration;
        logic [SLOT_W-1:0]  idx;
        logic               notify;
    } t_entry;

endpackage

// ===== src/osts_if.sv =====
interface osts_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] duration;
    logic [7:0]  slot_id;
    logic        notify;

    modport source (output valid, output op, output duration, output slot_id,
                    output notify, input ready);
    modport sink (input valid, input op, input duration, input slot_id,
                  input notify, output ready);
endinterface

interface osts_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] expired_mask;

    modport source (output valid, output status, output slot, output expired_mask,
                    input ready);
    modport sink (input valid, input status, input slot, input expired_mask,
                  output ready);
endinterface

// ===== src/one_shot_timer_slot_table.sv =====
// Table of 16 one-shot timer slots. A register item takes the lowest free slot
// (count zero, notify clear) and answers its number or a no-free-slot status; an
// unregister item clears one slot or answers out of range; a tick item decrements
// every nonzero count and answers a mask of the slots that ran out with notify
// set. Commands enter a two-item queue, so up to two can be taken while the
// table is busy and a result waits in the output register. The table is walked
// one slot per cycle by a single sequencer: a tick walks every slot, a register
// stops at the first free slot or at the last one, and an unregister or an unused
// opcode goes straight to its result without a walk. The table is cleared by reset.
module one_shot_timer_slot_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    osts_cmd_if.sink   i_cmd,
    osts_res_if.source o_res
);

    logic             q_valid;
    logic             q_pop;
    osts_pkg::t_entry q_entry;

    osts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_pop     (q_pop),
        .o_q_valid (q_valid),
        .o_q_entry (q_entry)
    );

    osts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule

// ===== src/osts_front.sv =====
module osts_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    osts_cmd_if.sink         i_cmd,
    input  logic             i_pop,
    output logic             o_q_valid,
    output osts_pkg::t_entry o_q_entry
);

    osts_pkg::t_entry r_q [0:1];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    osts_pkg::t_entry n_entry;
    logic             push;
    logic             pop;

    // classify
    always_comb begin
        n_entry.duration = i_cmd.duration;
        n_entry.idx      = i_cmd.slot_id[osts_pkg::SLOT_W-1:0];
        n_entry.notify   = i_cmd.notify;
        case (i_cmd.op)
            osts_pkg::OP_REGISTER: begin
                n_entry.kind = osts_pkg::K_REG;
            end
            osts_pkg::OP_UNREGISTER: begin
                if (i_cmd.slot_id < osts_pkg::SLOT_ID_LIMIT) begin
                    n_entry.kind = osts_pkg::K_UNREG;
                end else begin
                    n_entry.kind = osts_pkg::K_RANGE;
                end
            end
            osts_pkg::OP_TICK: begin
                n_entry.kind = osts_pkg::K_TICK;
            end
            default: begin
                n_entry.kind = osts_pkg::K_NOP;
            end
        endcase
    end

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push        = i_cmd.valid && i_cmd.ready;
    assign pop         = i_pop && o_q_valid;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_entry   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wr_ptr] <= n_entry;
                r_wr_ptr      <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== src/osts_back.sv =====
module osts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  osts_pkg::t_entry i_q_entry,
    output logic             o_pop,
    osts_res_if.source       o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [31:0]                   r_count  [0:osts_pkg::SLOTS-1];
    logic [osts_pkg::SLOTS-1:0]    r_notify;
    logic [osts_pkg::SLOTS-1:0]    r_mask;
    logic [osts_pkg::SLOT_W-1:0]   r_idx;
    osts_pkg::t_entry              r_cur;
    logic [1:0]                    r_status;
    logic [3:0]                    r_slot;
    logic                          r_out_valid;
    logic [1:0]                    r_out_status;
    logic [3:0]                    r_out_slot;
    logic [15:0]                   r_out_mask;

    logic [31:0] cur_count;
    logic        cur_free;

    assign cur_count = r_count[r_idx];
    assign cur_free  = (cur_count == 32'd0) && !r_notify[r_idx];
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.slot         = r_out_slot;
    assign o_res.expired_mask = r_out_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_notify    <= '0;
            for (int i = 0; i < osts_pkg::SLOTS; i++) begin
                r_count[i] <= 32'd0;
            end
        end else begin
            if (r_out_valid && o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cur    <= i_q_entry;
                        r_idx    <= '0;
                        r_mask   <= '0;
                        r_status <= (i_q_entry.kind == osts_pkg::K_RANGE) ?
                                    osts_pkg::ST_RANGE : osts_pkg::ST_OK;
                        r_slot   <= 4'd0;
                        case (i_q_entry.kind)
                            osts_pkg::K_REG, osts_pkg::K_TICK: begin
                                r_state <= S_WALK;
                            end
                            osts_pkg::K_UNREG: begin
                                r_count[i_q_entry.idx]  <= 32'd0;
                                r_notify[i_q_entry.idx] <= 1'b0;
                                r_state                 <= S_DONE;
                            end
                            osts_pkg::K_RANGE: begin
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_cur.kind == osts_pkg::K_REG) begin
                        if (cur_free) begin
                            r_count[r_idx]  <= r_cur.duration;
                            r_notify[r_idx] <= r_cur.notify;
                            r_slot          <= 4'(r_idx);
                            r_state         <= S_DONE;
                        end else if (r_idx == osts_pkg::LAST_IDX) begin
                            r_status <= osts_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_idx <= r_idx + osts_pkg::SLOT_W'(1);
                        end
                    end else begin
                        if (cur_count != 32'd0) begin
                            r_count[r_idx] <= cur_count - 32'd1;
                            if (cur_count == 32'd1 && r_notify[r_idx]) begin
                                r_mask[r_idx]   <= 1'b1;
                                r_notify[r_idx] <= 1'b0;
                            end
                        end
                        if (r_idx == osts_pkg::LAST_IDX) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx + osts_pkg::SLOT_W'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_slot   <= r_slot;
                        r_out_mask   <= 16'(r_mask);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
